@@ rtl/core/tvsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_pkg
// Shared constants, types and the sync marker table for the tagged value
// stream parser.
// ----------------------------------------------------------------------------
package tvsp_pkg;

    localparam int SYNC_LEN    = 28;
    localparam int SYNC_W      = 5;
    localparam int MAX_VARS    = 64;
    localparam int VAR_ID_W    = 6;
    localparam int TEXT_W      = 19;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    localparam logic [31:0] LOG_ID = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REG_VAR_COUNT    = 3'd0,
        REG_VAR_TYPE_MAP = 3'd1,
        REG_OWNED_MAP    = 3'd2,
        REG_MAX_TEXT_LEN = 3'd3,
        REG_HOST_LEVEL   = 3'd4
    } tvsp_reg_idx_t;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_STRING = 2'd1,
        KIND_LOG    = 2'd2,
        KIND_ERROR  = 2'd3
    } tvsp_kind_t;

    typedef enum logic [1:0] {
        CMD_NUM_SHIFT = 2'd0,
        CMD_NUM_LAST  = 2'd1,
        CMD_TEXT      = 2'd2,
        CMD_ERROR     = 2'd3
    } tvsp_op_t;

    typedef struct packed {
        tvsp_op_t              op;
        tvsp_kind_t            kind;
        logic [VAR_ID_W-1:0]   var_id;
        logic [7:0]            data;
        logic                  last;
        logic [7:0]            level;
    } tvsp_cmd_t;

    typedef struct packed {
        logic [6:0]            var_count;
        logic [63:0]           var_type_map;
        logic [63:0]           owned_map;
        logic [TEXT_W-1:0]     max_text_len;
        logic [7:0]            host_log_level;
    } tvsp_cfg_t;

    function automatic logic [7:0] marker_byte(input logic [SYNC_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:  b = 8'h0A;
            5'd1:  b = 8'h78;
            5'd2:  b = 8'h73;
            5'd3:  b = 8'h79;
            5'd4:  b = 8'h73;
            5'd5:  b = 8'h67;
            5'd6:  b = 8'h75;
            5'd7:  b = 8'h61;
            5'd8:  b = 8'h72;
            5'd9:  b = 8'h64;
            5'd10: b = 8'h64;
            5'd11: b = 8'h5F;
            5'd12: b = 8'h69;
            5'd13: b = 8'h6E;
            5'd14: b = 8'h69;
            5'd15: b = 8'h74;
            5'd16: b = 8'h5F;
            5'd17: b = 8'h76;
            5'd18: b = 8'h65;
            5'd19: b = 8'h72;
            5'd20: b = 8'h73;
            5'd21: b = 8'h69;
            5'd22: b = 8'h6F;
            5'd23: b = 8'h6E;
            5'd24: b = 8'h5F;
            5'd25: b = 8'h31;
            5'd26: b = 8'h0A;
            5'd27: b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/tvsp_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module tvsp_regs
    import tvsp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output tvsp_cfg_t                  cfg
);

    logic [6:0]        var_count_reg;
    logic [63:0]       var_type_map_reg;
    logic [63:0]       owned_map_reg;
    logic [TEXT_W-1:0] max_text_len_reg;
    logic [7:0]        host_log_level_reg;

    logic          wr_en;
    tvsp_reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = tvsp_reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_count_reg      <= '0;
            var_type_map_reg   <= '0;
            owned_map_reg      <= '0;
            max_text_len_reg   <= TEXT_W'(262144);
            host_log_level_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_VAR_COUNT:    var_count_reg      <= pwdata[6:0];
                REG_VAR_TYPE_MAP: var_type_map_reg   <= pwdata;
                REG_OWNED_MAP:    owned_map_reg      <= pwdata;
                REG_MAX_TEXT_LEN: max_text_len_reg   <= pwdata[TEXT_W-1:0];
                REG_HOST_LEVEL:   host_log_level_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VAR_COUNT:    prdata = {57'd0, var_count_reg};
            REG_VAR_TYPE_MAP: prdata = var_type_map_reg;
            REG_OWNED_MAP:    prdata = owned_map_reg;
            REG_MAX_TEXT_LEN: prdata = {{(APB_DATA_W-TEXT_W){1'b0}}, max_text_len_reg};
            REG_HOST_LEVEL:   prdata = {56'd0, host_log_level_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.var_count      = var_count_reg;
    assign cfg.var_type_map   = var_type_map_reg;
    assign cfg.owned_map      = owned_map_reg;
    assign cfg.max_text_len   = max_text_len_reg;
    assign cfg.host_log_level = host_log_level_reg;

endmodule
`default_nettype wire

@@ rtl/core/tvsp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_front
// Byte classifier: sync search, id collection and record tracking. Turns each
// accepted byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module tvsp_front
    import tvsp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic       req_type,
    input  wire logic [7:0] in_byte,
    input  wire tvsp_cfg_t  cfg,
    output logic            push,
    output tvsp_cmd_t       push_cmd
);

    logic              halted_reg,     halted_next;
    logic [SYNC_W-1:0] sync_pos_reg,   sync_pos_next;
    logic [31:0]       id_shift_reg,   id_shift_next;
    logic [2:0]        id_count_reg,   id_count_next;
    logic [7:0]        level_reg,      level_next;
    logic              level_have_reg, level_have_next;
    logic [3:0]        num_count_reg,  num_count_next;
    logic [TEXT_W-1:0] text_count_reg, text_count_next;

    logic [31:0]         id_cat;
    logic                id_ok;
    logic                shown;
    logic                keep;
    logic [3:0]          num_inc;
    logic [VAR_ID_W-1:0] idx;

    assign id_cat  = {id_shift_reg[23:0], in_byte};
    assign id_ok   = (id_cat < {25'd0, cfg.var_count}) && (id_cat < 32'(MAX_VARS))
                     && cfg.owned_map[id_cat[VAR_ID_W-1:0]];
    assign shown   = level_reg <= cfg.host_log_level;
    assign keep    = text_count_reg < cfg.max_text_len;
    assign num_inc = num_count_reg + 4'd1;
    assign idx     = id_shift_reg[VAR_ID_W-1:0];

    always_comb begin
        halted_next     = halted_reg;
        sync_pos_next   = sync_pos_reg;
        id_shift_next   = id_shift_reg;
        id_count_next   = id_count_reg;
        level_next      = level_reg;
        level_have_next = level_have_reg;
        num_count_next  = num_count_reg;
        text_count_next = text_count_reg;
        push            = 1'b0;
        push_cmd.op     = CMD_NUM_SHIFT;
        push_cmd.kind   = KIND_NUMBER;
        push_cmd.var_id = '0;
        push_cmd.data   = in_byte;
        push_cmd.last   = 1'b0;
        push_cmd.level  = '0;

        if (in_accept) begin
            if (req_type) begin
                halted_next     = 1'b0;
                sync_pos_next   = SYNC_W'(1);
                id_shift_next   = '0;
                id_count_next   = '0;
                level_next      = '0;
                level_have_next = 1'b0;
                num_count_next  = '0;
                text_count_next = '0;
            end else if (halted_reg) begin
                halted_next = 1'b1;
            end else if (sync_pos_reg < SYNC_W'(SYNC_LEN)) begin
                if (marker_byte(sync_pos_reg) == in_byte) begin
                    sync_pos_next = sync_pos_reg + SYNC_W'(1);
                end else begin
                    sync_pos_next = SYNC_W'(1);
                end
            end else if (id_count_reg < 3'd4) begin
                id_shift_next = id_cat;
                id_count_next = id_count_reg + 3'd1;
                if (id_count_reg == 3'd3) begin
                    level_have_next = 1'b0;
                    num_count_next  = '0;
                    text_count_next = '0;
                    if (id_cat != LOG_ID && !id_ok) begin
                        halted_next   = 1'b1;
                        push          = 1'b1;
                        push_cmd.op   = CMD_ERROR;
                        push_cmd.kind = KIND_ERROR;
                        push_cmd.data = '0;
                    end
                end
            end else if (id_shift_reg == LOG_ID) begin
                push_cmd.kind  = KIND_LOG;
                push_cmd.op    = CMD_TEXT;
                push_cmd.level = level_reg;
                if (!level_have_reg) begin
                    level_next      = in_byte;
                    level_have_next = 1'b1;
                    if (in_byte == 8'd0) begin
                        id_count_next   = '0;
                        level_have_next = 1'b0;
                        text_count_next = '0;
                        num_count_next  = '0;
                    end
                end else if (in_byte != 8'd0) begin
                    if (keep) begin
                        text_count_next = text_count_reg + TEXT_W'(1);
                    end
                    push = keep && shown;
                end else begin
                    id_count_next   = '0;
                    level_have_next = 1'b0;
                    text_count_next = '0;
                    num_count_next  = '0;
                    push            = shown;
                    push_cmd.last   = 1'b1;
                end
            end else if (cfg.var_type_map[idx]) begin
                push_cmd.kind   = KIND_STRING;
                push_cmd.op     = CMD_TEXT;
                push_cmd.var_id = idx;
                if (in_byte != 8'd0) begin
                    if (keep) begin
                        text_count_next = text_count_reg + TEXT_W'(1);
                    end
                    push = keep;
                end else begin
                    id_count_next   = '0;
                    level_have_next = 1'b0;
                    text_count_next = '0;
                    num_count_next  = '0;
                    push            = 1'b1;
                    push_cmd.last   = 1'b1;
                end
            end else begin
                push            = 1'b1;
                push_cmd.var_id = idx;
                num_count_next  = num_inc;
                if (num_inc >= 4'd8) begin
                    push_cmd.op     = CMD_NUM_LAST;
                    id_count_next   = '0;
                    level_have_next = 1'b0;
                    text_count_next = '0;
                    num_count_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg     <= 1'b1;
            sync_pos_reg   <= SYNC_W'(1);
            id_shift_reg   <= '0;
            id_count_reg   <= '0;
            level_reg      <= '0;
            level_have_reg <= 1'b0;
            num_count_reg  <= '0;
            text_count_reg <= '0;
        end else begin
            halted_reg     <= halted_next;
            sync_pos_reg   <= sync_pos_next;
            id_shift_reg   <= id_shift_next;
            id_count_reg   <= id_count_next;
            level_reg      <= level_next;
            level_have_reg <= level_have_next;
            num_count_reg  <= num_count_next;
            text_count_reg <= text_count_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/tvsp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_queue
// Small command FIFO between the classifier and the back end.
// ----------------------------------------------------------------------------
module tvsp_queue
    import tvsp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire tvsp_cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output logic           q_valid,
    output tvsp_cmd_t      q_cmd
);

    tvsp_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue written while full");
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("command queue read while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count out of range");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("command queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

@@ rtl/core/tvsp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvsp_back
// Executes queued commands: assembles number words and drives the result
// output register.
// ----------------------------------------------------------------------------
module tvsp_back
    import tvsp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  wire tvsp_cmd_t              q_cmd,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    output logic      [1:0]             m_tuser,
    output logic                        m_tlast
);

    logic [63:0]         num_shift_reg,  num_shift_next;
    logic                out_valid_reg,  out_valid_next;
    tvsp_kind_t          out_kind_reg,   out_kind_next;
    logic [VAR_ID_W-1:0] out_id_reg,     out_id_next;
    logic [63:0]         out_bits_reg,   out_bits_next;
    logic [7:0]          out_char_reg,   out_char_next;
    logic                out_last_reg,   out_last_next;
    logic [7:0]          out_level_reg,  out_level_next;

    logic out_free;
    logic shift_only;

    assign out_free   = !out_valid_reg || m_tready;
    assign shift_only = q_cmd.op == CMD_NUM_SHIFT;
    assign pop        = q_valid && (shift_only || out_free);

    always_comb begin
        num_shift_next = num_shift_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_bits_next  = out_bits_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_level_next = out_level_reg;
        if (pop) begin
            case (q_cmd.op)
                CMD_NUM_SHIFT: begin
                    num_shift_next = {num_shift_reg[55:0], q_cmd.data};
                end
                CMD_NUM_LAST: begin
                    num_shift_next = {num_shift_reg[55:0], q_cmd.data};
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_NUMBER;
                    out_id_next    = q_cmd.var_id;
                    out_bits_next  = {num_shift_reg[55:0], q_cmd.data};
                    out_char_next  = '0;
                    out_last_next  = 1'b0;
                    out_level_next = '0;
                end
                CMD_TEXT: begin
                    out_valid_next = 1'b1;
                    out_kind_next  = q_cmd.kind;
                    out_id_next    = q_cmd.var_id;
                    out_bits_next  = '0;
                    out_char_next  = q_cmd.last ? 8'd0 : q_cmd.data;
                    out_last_next  = q_cmd.last;
                    out_level_next = q_cmd.level;
                end
                default: begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ERROR;
                    out_id_next    = '0;
                    out_bits_next  = '0;
                    out_char_next  = '0;
                    out_last_next  = 1'b0;
                    out_level_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        num_shift_reg <= num_shift_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_bits_reg  <= out_bits_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_level_reg <= out_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_level_reg, out_char_reg, out_bits_reg, out_id_reg};

`ifndef NO_ASSERTIONS
    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !shift_only) |-> out_free)
        else $error("result issued into an occupied output register");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !shift_only) |=> m_tvalid)
        else $error("issued result not presented");
    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tdata == '0 && !m_tlast))
        else $error("error result carries payload");
`endif

endmodule
`default_nettype wire

@@ rtl/core/tagged_value_stream_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_value_stream_parser_top
// Parser for a synced, id-tagged byte stream carrying number, string and log
// records.
//
//   port group  dir  content
//   ----------  ---  -----------------------------------------------------
//   APB         in   config regs at 8*i: var_count, var_type_map,
//                    owned_map, max_text_len, host_log_level
//   s_*         in   tuser[0] restart, tdata[7:0] link byte
//   m_*         out  tuser kind, tlast terminator, tdata packed fields
//
// One input transfer per cycle while s_tready is high; each byte updates only
// classifier state. A result passes through the command queue, then the output
// register. s_tready falls only when the four-entry command queue is full,
// i.e. after the result side has stalled for a while. After reset the parser
// is halted and ignores data until a restart transfer.
// ----------------------------------------------------------------------------
module tagged_value_stream_parser_top
    import tvsp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]             s_tuser,   // [0] req_type
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [5:0] var_id, [69:6] number_bits, [77:70] text_char, [85:78] msg_level
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    output logic      [1:0]             m_tuser,   // [1:0] result_kind
    output logic                        m_tlast    // text_last
);

    tvsp_cfg_t cfg;
    tvsp_cmd_t push_cmd;
    tvsp_cmd_t q_cmd;
    logic      push;
    logic      full;
    logic      pop;
    logic      q_valid;
    logic      in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    tvsp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tvsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .req_type  (s_tuser[0]),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tvsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    tvsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ tb/tagged_value_stream_parser_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tagged_value_stream_parser_top_test
// Self-checking bench for the tagged value stream parser. A directed table
// covers halt after reset, marker loss, number, string and log records,
// truncation, suppressed logs and id errors. Random phases follow, each under
// a different register setting, mostly well-formed records with some stray
// bytes and restarts. Every result transfer is compared with the in-bench
// model or a typed table entry. Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tagged_value_stream_parser_top_test;
    import tvsp_pkg::*;

    typedef struct packed {
        tvsp_kind_t  kind;
        logic [5:0]  var_id;
        logic [63:0] number_bits;
        logic [7:0]  text_char;
        logic        text_last;
        logic [7:0]  msg_level;
    } parser_result_t;

    typedef enum logic [1:0] {
        ROW_DATA    = 2'd0,
        ROW_RESTART = 2'd1,
        ROW_SYNC    = 2'd2
    } row_op_t;

    typedef struct packed {
        row_op_t        op;
        logic [3:0]     nbytes;
        logic [63:0]    word;
        logic           typed;
        logic           hit;
        parser_result_t res;
    } stim_row_t;

    localparam parser_result_t NO_RESULT    = '{KIND_NUMBER, 6'd0, 64'd0, 8'd0, 1'b0, 8'd0};
    localparam parser_result_t ERROR_RESULT = '{KIND_ERROR, 6'd0, 64'd0, 8'd0, 1'b0, 8'd0};
    // sync marker, byte 0 in the low bits
    localparam logic [SYNC_LEN*8-1:0] MARKER_BYTES =
        224'h000A_315F_6E6F_6973_7265_765F_7469_6E69_5F64_6472_6175_6773_7973_780A;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    // register shadow
    logic [6:0]  cfg_var_count    = 7'd0;
    logic [63:0] cfg_type_map     = 64'd0;
    logic [63:0] cfg_owned_map    = 64'd0;
    logic [18:0] cfg_max_text_len = 19'd262144;
    logic [7:0]  cfg_host_level   = 8'd0;
    int          valid_ids[$];

    // parser model state
    bit          p_halted     = 1'b1;
    int          p_sync_pos   = 1;
    logic [31:0] p_id         = '0;
    int          p_id_cnt     = 0;
    logic [7:0]  p_level      = '0;
    bit          p_level_have = 1'b0;
    logic [63:0] p_num        = '0;
    int          p_num_cnt    = 0;
    int          p_text_cnt   = 0;

    parser_result_t pending_results[$];
    int             error_count  = 0;
    int             active_items = 0;
    bit             tx_steady    = 1'b0;
    bit             rx_steady    = 1'b0;

    stim_row_t directed_rows [31] = '{
        '{ROW_DATA,    4'd1, 64'h55,                  1'b1, 1'b0, NO_RESULT},
        '{ROW_RESTART, 4'd0, 64'h0,                   1'b1, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd2, 64'h7800,                1'b1, 1'b0, NO_RESULT},
        '{ROW_SYNC,    4'd0, 64'h0,                   1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd4, 64'h0,                   1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
          '{KIND_NUMBER, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0, 8'd0}},
        '{ROW_DATA,    4'd4, 64'h3F,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'hFF,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h01,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h80,                  1'b1, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h00,                  1'b1, 1'b1,
          '{KIND_STRING, 6'd63, 64'd0, 8'd0, 1'b1, 8'd0}},
        '{ROW_DATA,    4'd4, 64'hFFFF_FFFF,           1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h04,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h7F,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h00,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd4, 64'hFFFF_FFFF,           1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'hFF,                  1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h41,                  1'b1, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h00,                  1'b1, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd4, 64'hFFFF_FFFF,           1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd1, 64'h00,                  1'b1, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd4, 64'h0,                   1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd8, 64'h0,                   1'b1, 1'b1,
          '{KIND_NUMBER, 6'd0, 64'd0, 8'd0, 1'b0, 8'd0}},
        '{ROW_DATA,    4'd4, 64'h2,                   1'b1, 1'b1, ERROR_RESULT},
        '{ROW_DATA,    4'd1, 64'hAA,                  1'b1, 1'b0, NO_RESULT},
        '{ROW_RESTART, 4'd0, 64'h0,                   1'b1, 1'b0, NO_RESULT},
        '{ROW_SYNC,    4'd0, 64'h0,                   1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd4, 64'h40,                  1'b1, 1'b1, ERROR_RESULT},
        '{ROW_RESTART, 4'd0, 64'h0,                   1'b1, 1'b0, NO_RESULT},
        '{ROW_SYNC,    4'd0, 64'h0,                   1'b0, 1'b0, NO_RESULT},
        '{ROW_DATA,    4'd4, 64'hFFFF_FFFE,           1'b1, 1'b1, ERROR_RESULT}
    };

    tagged_value_stream_parser_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void close_record();
        p_id_cnt     = 0;
        p_level_have = 1'b0;
        p_text_cnt   = 0;
        p_num_cnt    = 0;
    endfunction

    function automatic bit take_char();
        if (p_text_cnt < int'(cfg_max_text_len)) begin
            p_text_cnt++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advances the parser state by one transfer; returns 1 when a result is due
    function automatic bit parse_step(input logic restart, input logic [7:0] b,
                                      output parser_result_t res);
        logic [5:0] idx;
        bit         shown;
        res = NO_RESULT;
        if (restart) begin
            p_halted     = 1'b0;
            p_sync_pos   = 1;
            p_id         = '0;
            p_id_cnt     = 0;
            p_level      = '0;
            p_level_have = 1'b0;
            p_num        = '0;
            p_num_cnt    = 0;
            p_text_cnt   = 0;
            return 1'b0;
        end
        if (p_halted) return 1'b0;
        if (p_sync_pos < SYNC_LEN) begin
            p_sync_pos = (MARKER_BYTES[8*p_sync_pos +: 8] == b) ? p_sync_pos + 1 : 1;
            return 1'b0;
        end
        if (p_id_cnt < 4) begin
            p_id = {p_id[23:0], b};
            p_id_cnt++;
            if (p_id_cnt == 4) begin
                p_level_have = 1'b0;
                p_num_cnt    = 0;
                p_text_cnt   = 0;
                if (p_id != LOG_ID && !(p_id < cfg_var_count && p_id < MAX_VARS &&
                                        cfg_owned_map[p_id[5:0]])) begin
                    p_halted = 1'b1;
                    res.kind = KIND_ERROR;
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        if (p_id == LOG_ID) begin
            if (!p_level_have) begin
                p_level      = b;
                p_level_have = 1'b1;
                if (b == 8'd0) close_record();
                return 1'b0;
            end
            shown         = p_level <= cfg_host_level;
            res.kind      = KIND_LOG;
            res.msg_level = p_level;
            res.text_char = b;
            if (b != 8'd0) return take_char() && shown;
            close_record();
            res.text_last = 1'b1;
            return shown;
        end
        idx        = p_id[5:0];
        res.var_id = idx;
        if (cfg_type_map[idx]) begin
            res.kind      = KIND_STRING;
            res.text_char = b;
            if (b != 8'd0) return take_char();
            close_record();
            res.text_last = 1'b1;
            return 1'b1;
        end
        p_num = {p_num[55:0], b};
        p_num_cnt++;
        if (p_num_cnt < 8) return 1'b0;
        close_record();
        res.kind        = KIND_NUMBER;
        res.number_bits = p_num;
        return 1'b1;
    endfunction

    // leaves psel high after the access edge; set_config closes the burst
    task automatic write_reg(input tvsp_reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
    endtask

    task automatic set_config(input logic [6:0] vc, input logic [63:0] tm,
                              input logic [63:0] om, input logic [18:0] mtl,
                              input logic [7:0] hll);
        int i;
        write_reg(REG_VAR_COUNT, 64'(vc));
        write_reg(REG_VAR_TYPE_MAP, tm);
        write_reg(REG_OWNED_MAP, om);
        write_reg(REG_MAX_TEXT_LEN, 64'(mtl));
        write_reg(REG_HOST_LEVEL, 64'(hll));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_var_count    = vc;
        cfg_type_map     = tm;
        cfg_owned_map    = om;
        cfg_max_text_len = mtl;
        cfg_host_level   = hll;
        valid_ids.delete();
        for (i = 0; i < MAX_VARS; i++) begin
            if (i < vc && om[i]) valid_ids.push_back(i);
        end
    endtask

    // one input transfer; a typed expectation replaces the model's result
    task automatic feed(input logic restart, input logic [7:0] b,
                        input bit typed = 1'b0, input bit typed_hit = 1'b0,
                        input parser_result_t typed_res = NO_RESULT);
        int             gap;
        bit             hit;
        parser_result_t res;
        if (restart || !p_halted) active_items++;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        hit = parse_step(restart, b, res);
        if (typed) begin
            hit = typed_hit;
            res = typed_res;
        end
        if (hit) pending_results.push_back(res);
    endtask

    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic send_text();
        int n;
        int i;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        for (i = 0; i < n; i++) feed(1'b0, 8'($urandom_range(1, 255)));
        feed(1'b0, 8'h00);
    endtask

    task automatic random_record();
        int          pick;
        int          i;
        logic [31:0] id;
        logic [63:0] word;
        logic [7:0]  lvl;
        if ($urandom_range(0, 149) == 0) wait_drained(0);
        if (p_halted) begin
            if ($urandom_range(0, 3) == 0) feed(1'b0, 8'($urandom));
            feed(1'b1, 8'($urandom));
            return;
        end
        if (p_sync_pos < SYNC_LEN) begin
            if ($urandom_range(0, 99) == 0) feed(1'b0, 8'($urandom));
            else feed(1'b0, MARKER_BYTES[8*p_sync_pos +: 8]);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            feed(1'b1, 8'($urandom));
        end else if (pick < 5) begin
            feed(1'b0, 8'($urandom));
        end else if (pick < 25) begin
            for (i = 3; i >= 0; i--) feed(1'b0, LOG_ID[8*i +: 8]);
            case ($urandom_range(0, 3))
                0: lvl = 8'd0;
                1: lvl = 8'($urandom_range(0, cfg_host_level));
                2: lvl = cfg_host_level + 8'd1;
                default: lvl = 8'($urandom);
            endcase
            feed(1'b0, lvl);
            if (lvl != 8'd0) send_text();
        end else begin
            if (pick < 37 || valid_ids.size() == 0) begin
                case ($urandom_range(0, 2))
                    0: id = $urandom;
                    1: id = $urandom_range(0, 127);
                    default: id = $urandom_range(0, 63);
                endcase
            end else begin
                id = valid_ids[$urandom_range(0, valid_ids.size() - 1)];
            end
            for (i = 3; i >= 0; i--) feed(1'b0, id[8*i +: 8]);
            if (p_halted) return;
            if (cfg_type_map[id[5:0]]) begin
                send_text();
            end else begin
                case ($urandom_range(0, 7))
                    0: word = 64'd0;
                    1: word = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: word = {$urandom, $urandom};
                endcase
                for (i = 7; i >= 0; i--) feed(1'b0, word[8*i +: 8]);
            end
        end
    endtask

    initial begin : result_sink
        parser_result_t want;
        int             stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: kind %0d, tdata %h", m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                    error_count++;
                end
                if (m_tdata[5:0] !== want.var_id) begin
                    $error("var_id: expected %0d, actual %0d", want.var_id, m_tdata[5:0]);
                    error_count++;
                end
                if (m_tdata[69:6] !== want.number_bits) begin
                    $error("number_bits: expected %h, actual %h",
                           want.number_bits, m_tdata[69:6]);
                    error_count++;
                end
                if (m_tdata[77:70] !== want.text_char) begin
                    $error("text_char: expected %h, actual %h", want.text_char, m_tdata[77:70]);
                    error_count++;
                end
                if (m_tlast !== want.text_last) begin
                    $error("text_last: expected %0d, actual %0d", want.text_last, m_tlast);
                    error_count++;
                end
                if (m_tdata[85:78] !== want.msg_level) begin
                    $error("msg_level: expected %0d, actual %0d", want.msg_level, m_tdata[85:78]);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        int        r;
        int        k;
        int        phase;
        int        phase_end;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(7'd64, 64'h8000_0000_0000_0002, ~64'h4, 19'd2, 8'd4);
        for (r = 0; r < 31; r++) begin
            row = directed_rows[r];
            case (row.op)
                ROW_RESTART: begin
                    feed(1'b1, 8'h00, row.typed, row.hit, row.res);
                end
                ROW_SYNC: begin
                    while (!p_halted && p_sync_pos < SYNC_LEN)
                        feed(1'b0, MARKER_BYTES[8*p_sync_pos +: 8]);
                end
                default: begin
                    for (k = row.nbytes; k > 0; k--)
                        feed(1'b0, row.word[8*k-1 -: 8], row.typed && k == 1,
                             row.hit, row.res);
                end
            endcase
        end
        wait_drained(8);

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(7'd64, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF,
                              19'd262144, 8'd255);
                1: set_config(7'd0, 64'd0, 64'd0, 19'd0, 8'd0);
                2: set_config(7'($urandom_range(1, 63)), {$urandom, $urandom},
                              {$urandom, $urandom}, 19'($urandom_range(0, 4)), 8'($urandom));
                3: set_config(7'd64, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                              19'd1, 8'd128);
                4: set_config(7'd64, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 19'd3, 8'($urandom));
                default: set_config(7'($urandom_range(0, 64)), {$urandom, $urandom},
                                    {$urandom, $urandom},
                                    $urandom_range(0, 1) ? 19'd262144
                                                         : 19'($urandom_range(0, 8)),
                                    8'($urandom));
            endcase
            phase_end = active_items + 155;
            while (active_items < phase_end) random_record();
            wait_drained(8);
        end

        wait_drained(10);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tvsp_pkg.sv
rtl/core/tvsp_regs.sv
rtl/core/tvsp_front.sv
rtl/core/tvsp_queue.sv
rtl/core/tvsp_back.sv
rtl/core/tagged_value_stream_parser_top.sv
tb/tagged_value_stream_parser_top_test.sv
